@@ rtl/tccw_pkg.sv @@
// ============================================================================
// tccw_pkg
// Shared types and constants for the text console character writer.
// ============================================================================
package tccw_pkg;

    // item kinds
    typedef enum logic [1:0] {
        KIND_PUT   = 2'd0,
        KIND_SET   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    // register map, word index taken from paddr[3:2]
    localparam int          APB_AW      = 4;
    localparam logic [1:0]  REG_COLUMNS = 2'd0;
    localparam logic [1:0]  REG_ROWS    = 2'd1;
    localparam logic [1:0]  REG_ATTR    = 2'd2;

    localparam logic [6:0]  COLUMNS_RST = 7'd80;
    localparam logic [4:0]  ROWS_RST    = 5'd25;
    localparam logic [7:0]  ATTR_RST    = 8'h0F;

    // character codes
    localparam logic [7:0]  CH_BS       = 8'h08;
    localparam logic [7:0]  CH_TAB      = 8'h09;
    localparam logic [7:0]  CH_LF       = 8'h0A;
    localparam logic [7:0]  CH_CR       = 8'h0D;
    localparam logic [7:0]  BLANK_CHAR  = 8'h20;

    localparam logic [15:0] RESET_CELL  = 16'h0F20;

    // width of linear screen index arithmetic (7-bit column, 5-bit row)
    localparam int          IDX_W       = 13;

    // outcome of one item on the cursor
    typedef struct packed {
        logic [6:0] new_x;
        logic [4:0] new_y;
        logic       wr_en;   // printable character goes to the cell at wr_x, wr_y
        logic [6:0] wr_x;
        logic [4:0] wr_y;
        logic       scroll;
        logic [6:0] pos_x;   // clamped col/row of the item
        logic [4:0] pos_y;
    } step_t;

endpackage

@@ rtl/tccw_cursor_step.sv @@
// ============================================================================
// tccw_cursor_step
// Cursor update for one item: clamping, control codes, wrap and scroll flag.
// ============================================================================
module tccw_cursor_step
    import tccw_pkg::*;
(
    input  kind_t      kind,
    input  logic [7:0] char_code,
    input  logic [6:0] col,
    input  logic [4:0] row,
    input  logic [6:0] cur_x,
    input  logic [4:0] cur_y,
    input  logic [6:0] ncols,
    input  logic [4:0] nrows,
    output step_t      step
);

    logic [6:0] ncm1;
    logic [4:0] nrm1;
    logic [6:0] cx;
    logic [4:0] cy;
    logic [6:0] px;
    logic [4:0] py;
    logic [7:0] x1;
    logic [5:0] y1;
    logic       put_wr;
    logic       put_scroll;

    assign ncm1 = ncols - 7'd1;
    assign nrm1 = nrows - 5'd1;
    assign cx   = (cur_x > ncm1) ? ncm1 : cur_x;
    assign cy   = (cur_y > nrm1) ? nrm1 : cur_y;
    assign px   = (col > ncm1) ? ncm1 : col;
    assign py   = (row > nrm1) ? nrm1 : row;

    always_comb begin
        x1     = {1'b0, cx};
        y1     = {1'b0, cy};
        put_wr = 1'b0;
        case (char_code)
            CH_BS: begin
                if (cx != 7'd0) begin
                    x1 = {1'b0, cx} - 8'd1;
                end
            end
            CH_TAB: begin
                x1 = ({1'b0, cx} + 8'd4) & 8'hFC;
            end
            CH_CR: begin
                x1 = 8'd0;
            end
            CH_LF: begin
                x1 = 8'd0;
                y1 = y1 + 6'd1;
            end
            default: begin
                if (char_code >= BLANK_CHAR) begin
                    put_wr = 1'b1;
                    x1     = x1 + 8'd1;
                end
            end
        endcase
        if (x1 >= {1'b0, ncols}) begin
            x1 = 8'd0;
            y1 = y1 + 6'd1;
        end
        put_scroll = (y1 >= {1'b0, nrows});
        if (put_scroll) begin
            y1 = {1'b0, nrm1};
        end
    end

    always_comb begin
        step        = '0;
        step.wr_x   = cx;
        step.wr_y   = cy;
        step.pos_x  = px;
        step.pos_y  = py;
        case (kind)
            KIND_PUT: begin
                step.new_x  = x1[6:0];
                step.new_y  = y1[4:0];
                step.wr_en  = put_wr;
                step.scroll = put_scroll;
            end
            KIND_SET: begin
                step.new_x = px;
                step.new_y = py;
            end
            KIND_CLEAR: begin
                step.new_x = 7'd0;
                step.new_y = 5'd0;
            end
            default: begin
                step.new_x = cx;
                step.new_y = cy;
            end
        endcase
    end

endmodule

@@ rtl/text_console_char_writer_top.sv @@
// ============================================================================
// text_console_char_writer_top
// Text-mode console: screen memory of attribute/character cells and a cursor.
// ============================================================================
// Timing: put-character and set-cursor items may follow back to back while
// the result channel is not stalled. A read-cell item waits in ST_READ for
// the registered screen memory read. A put-character that scrolls, and a
// clear, walk the visible area one cell a cycle through the single write
// port of the screen memory, then finish in ST_FLUSH. After reset the whole
// memory (MAX_COLS*MAX_ROWS cells) is set to 0x0F20, one cell a cycle, and
// no item is taken until that pass is over; register writes are taken
// throughout. Registers sit at byte addresses 0x0 (columns), 0x4 (rows),
// 0x8 (attribute) and should only be written while no item is in flight.
// ============================================================================
module text_console_char_writer_top
    import tccw_pkg::*;
#(
    parameter int MAX_COLS = 80,
    parameter int MAX_ROWS = 25
) (
    input  logic              aclk,
    input  logic              aresetn,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // item channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_kind,
    input  logic [7:0]        s_char_code,
    input  logic [6:0]        s_col,
    input  logic [4:0]        s_row,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [6:0]        m_cursor_col,
    output logic [4:0]        m_cursor_row,
    output logic [10:0]       m_cursor_index,
    output logic [15:0]       m_cell_value,
    output logic              m_scrolled
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,  // clearing pass after reset
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,  // read data for a read-cell item
        ST_SWEEP = 5'b01000,  // scroll or clear walk
        ST_FLUSH = 5'b10000   // last write of the walk
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [6:0]    columns_reg;
    logic [4:0]    rows_reg;
    logic [7:0]    attr_reg;

    state_t        state_reg, state_next;
    logic [AW-1:0] k_reg, k_next;
    logic [6:0]    cx_reg, cx_next;
    logic [4:0]    cy_reg, cy_next;

    // walk write stage: each cell is written in the cycle after its source is read
    logic          pw_valid_reg, pw_valid_next;
    logic [AW-1:0] pw_addr_reg, pw_addr_next;
    logic          pw_move_reg, pw_move_next;

    logic [AW-1:0] sweep_last_reg, sweep_last_next;
    logic [AW-1:0] sweep_body_reg, sweep_body_next;

    logic          m_valid_reg, m_valid_next;
    logic [6:0]    o_col_reg, o_col_next;
    logic [4:0]    o_row_reg, o_row_next;
    logic [10:0]   o_idx_reg, o_idx_next;
    logic [15:0]   o_cell_reg, o_cell_next;
    logic          o_scr_reg, o_scr_next;

    // screen memory
    logic [15:0]   screen_mem [DEPTH];
    logic [15:0]   rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    logic cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= COLUMNS_RST;
            rows_reg    <= ROWS_RST;
            attr_reg    <= ATTR_RST;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_COLUMNS: columns_reg <= pwdata[6:0];
                REG_ROWS:    rows_reg    <= pwdata[4:0];
                REG_ATTR:    attr_reg    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_COLUMNS: prdata = {25'd0, columns_reg};
            REG_ROWS:    prdata = {27'd0, rows_reg};
            REG_ATTR:    prdata = {24'd0, attr_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Geometry in use, clamped to 1..MAX
    // ------------------------------------------------------------------
    logic [6:0] nc;
    logic [4:0] nr;

    always_comb begin
        if (columns_reg == 7'd0) begin
            nc = 7'd1;
        end else if ({1'b0, columns_reg} > 8'(MAX_COLS)) begin
            nc = 7'(MAX_COLS);
        end else begin
            nc = columns_reg;
        end
        if (rows_reg == 5'd0) begin
            nr = 5'd1;
        end else if ({2'b0, rows_reg} > 7'(MAX_ROWS)) begin
            nr = 5'(MAX_ROWS);
        end else begin
            nr = rows_reg;
        end
    end

    // ------------------------------------------------------------------
    // Cursor step and index arithmetic
    // ------------------------------------------------------------------
    kind_t      kind;
    step_t      step;
    logic       accept;
    logic [15:0] blank;

    assign kind   = kind_t'(s_kind);
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign blank   = {attr_reg, BLANK_CHAR};

    tccw_cursor_step u_step (
        .kind      (kind),
        .char_code (s_char_code),
        .col       (s_col),
        .row       (s_row),
        .cur_x     (cx_reg),
        .cur_y     (cy_reg),
        .ncols     (nc),
        .nrows     (nr),
        .step      (step)
    );

    logic [IDX_W-1:0] wr_idx, rd_idx, cur_idx, area, body, k_src;
    logic             move;

    // four small products in parallel, none chained
    assign wr_idx  = IDX_W'(step.wr_y)  * IDX_W'(nc) + IDX_W'(step.wr_x);
    assign rd_idx  = IDX_W'(step.pos_y) * IDX_W'(nc) + IDX_W'(step.pos_x);
    assign cur_idx = IDX_W'(step.new_y) * IDX_W'(nc) + IDX_W'(step.new_x);
    assign area    = IDX_W'(nr) * IDX_W'(nc);
    assign body    = area - IDX_W'(nc);

    // during a scroll cell k takes the cell one row below it; the bottom
    // row (and the whole area on a clear) takes blanks
    assign move  = (k_reg < sweep_body_reg);
    assign k_src = IDX_W'(k_reg) + IDX_W'(nc);

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        k_next          = k_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        pw_valid_next   = 1'b0;
        pw_addr_next    = k_reg;
        pw_move_next    = 1'b0;
        sweep_last_next = sweep_last_reg;
        sweep_body_next = sweep_body_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        o_col_next      = o_col_reg;
        o_row_next      = o_row_reg;
        o_idx_next      = o_idx_reg;
        o_cell_next     = o_cell_reg;
        o_scr_next      = o_scr_reg;
        case (state_reg)
            ST_INIT: begin
                k_next = k_reg + AW'(1);
                if (k_reg == AW'(DEPTH - 1)) begin
                    k_next     = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cx_next         = step.new_x;
                    cy_next         = step.new_y;
                    o_col_next      = step.new_x;
                    o_row_next      = step.new_y;
                    o_idx_next      = cur_idx[10:0];
                    o_cell_next     = 16'd0;
                    o_scr_next      = step.scroll;
                    k_next          = '0;
                    sweep_last_next = AW'(area - IDX_W'(1));
                    sweep_body_next = (kind == KIND_CLEAR) ? '0 : AW'(body);
                    if (kind == KIND_READ) begin
                        state_next = ST_READ;
                    end else if (kind == KIND_CLEAR || step.scroll) begin
                        state_next = ST_SWEEP;
                    end else begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            ST_READ: begin
                o_cell_next  = rdata_reg;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_SWEEP: begin
                pw_valid_next = 1'b1;
                pw_addr_next  = k_reg;
                pw_move_next  = move;
                k_next        = k_reg + AW'(1);
                if (k_reg == sweep_last_reg) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                k_next     = '0;
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            k_reg        <= '0;
            cx_reg       <= 7'd0;
            cy_reg       <= 5'd0;
            pw_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            cx_reg       <= cx_next;
            cy_reg       <= cy_next;
            pw_valid_reg <= pw_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pw_addr_reg    <= pw_addr_next;
        pw_move_reg    <= pw_move_next;
        sweep_last_reg <= sweep_last_next;
        sweep_body_reg <= sweep_body_next;
        o_col_reg      <= o_col_next;
        o_row_reg      <= o_row_next;
        o_idx_reg      <= o_idx_next;
        o_cell_reg     <= o_cell_next;
        o_scr_reg      <= o_scr_next;
    end

    // ------------------------------------------------------------------
    // Screen memory: one write port, one registered read port.
    // The walk reads cell k+columns while writing cell k-1, so the two
    // never meet; a written character is in memory before any later read.
    // ------------------------------------------------------------------
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = pw_addr_reg;
        mem_wdata = pw_move_reg ? rdata_reg : blank;
        if (state_reg == ST_INIT) begin
            mem_we    = 1'b1;
            mem_waddr = k_reg;
            mem_wdata = RESET_CELL;
        end else if (pw_valid_reg) begin
            mem_we = 1'b1;
        end else if (accept && kind == KIND_PUT && step.wr_en) begin
            mem_we    = 1'b1;
            mem_waddr = wr_idx[AW-1:0];
            mem_wdata = {attr_reg, s_char_code};
        end
    end

    always_comb begin
        if (state_reg == ST_SWEEP) begin
            mem_raddr = move ? k_src[AW-1:0] : k_reg;
        end else begin
            mem_raddr = rd_idx[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= screen_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    assign m_valid        = m_valid_reg;
    assign m_cursor_col   = o_col_reg;
    assign m_cursor_row   = o_row_reg;
    assign m_cursor_index = o_idx_reg;
    assign m_cell_value   = o_cell_reg;
    assign m_scrolled     = o_scr_reg;

endmodule

@@ rtl/tccw_checker.sv @@
// ============================================================================
// tccw_checker
// Port-level checks for the text console character writer, bound to the top.
// ============================================================================
module tccw_checker #(
    parameter int MAX_COLS = 80,
    parameter int MAX_ROWS = 25
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [6:0]  m_cursor_col,
    input logic [4:0]  m_cursor_row,
    input logic [10:0] m_cursor_index,
    input logic [15:0] m_cell_value,
    input logic        m_scrolled
);

    // a stalled result transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cursor_col) &&
            $stable(m_cursor_row) && $stable(m_cursor_index) &&
            $stable(m_cell_value) && $stable(m_scrolled))
        else $error("result changed while stalled");

    // reset starts the clearing pass: nothing taken, nothing offered
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block active straight after reset");

    // cursor stays on the largest screen
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_cursor_col} < 8'(MAX_COLS)) &&
            ({2'b0, m_cursor_row} < 7'(MAX_ROWS)))
        else $error("cursor off screen");

    // only a put-character scrolls, and it never carries a cell value
    a_scroll: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_scrolled |-> m_cell_value == 16'd0)
        else $error("scroll result carries a cell value");

endmodule

bind text_console_char_writer_top tccw_checker #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
) u_tccw_checker (.*);
